/* rtl/core/rapsf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and structs for the range-add prefix-sum tree.
package rapsf_pkg;

    localparam int TREE_SIZE  = 1024;
    localparam int SUM_WIDTH  = 48;
    localparam int ADDR_W     = $clog2(TREE_SIZE);
    localparam int POS_W      = $clog2(TREE_SIZE + 1);
    localparam int IDX_W      = 16;
    localparam int AMT_W      = 16;
    localparam int EXT_W      = IDX_W + 2;
    localparam int WALK_W     = (POS_W + 1 > EXT_W - 1) ? POS_W + 1 : EXT_W - 1;
    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic CMD_ADD       = 1'b0;
    localparam logic CMD_QUERY     = 1'b1;
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;
    localparam logic REG_BASE      = 1'b0;
    localparam logic REG_POSITIONS = 1'b1;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    addr;
        logic [SUM_WIDTH-1:0] slope_wdata;
        logic [SUM_WIDTH-1:0] offset_wdata;
    } tree_req_t;

    typedef struct packed {
        logic                 load;
        logic [SUM_WIDTH-1:0] sum;
        logic                 status;
    } result_t;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] mul_a;
        logic [EXT_W-1:0]     mul_b;
        logic [SUM_WIDTH-1:0] add_c;
    } alu_req_t;

endpackage

/* rtl/core/rapsf_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rapsf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/rapsf_alu.sv */
`timescale 1ns / 1ps
// Shared multiply-add unit: low SUM_WIDTH bits of a*b + c, signed operands.
module rapsf_alu (
    input  rapsf_pkg::alu_req_t                 req,
    output logic [rapsf_pkg::SUM_WIDTH-1:0]     result
);
    import rapsf_pkg::*;

    logic signed [SUM_WIDTH+EXT_W-1:0] product;

    assign product = $signed(req.mul_a) * $signed(req.mul_b);
    assign result  = product[SUM_WIDTH-1:0] + req.add_c;

endmodule

/* rtl/core/rapsf_seq.sv */
`timescale 1ns / 1ps
// Sequencer: clears the trees, walks them for adds and queries, drives the shared unit.
module rapsf_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  command,
    input  logic signed [rapsf_pkg::IDX_W-1:0]    low_index,
    input  logic signed [rapsf_pkg::IDX_W-1:0]    high_index,
    input  logic signed [rapsf_pkg::AMT_W-1:0]    amount,
    input  logic signed [rapsf_pkg::IDX_W-1:0]    base_index,
    input  logic [rapsf_pkg::POS_W-1:0]           n_eff,
    input  logic                                  out_free,
    input  logic [rapsf_pkg::SUM_WIDTH-1:0]       slope_rdata,
    input  logic [rapsf_pkg::SUM_WIDTH-1:0]       offset_rdata,
    output rapsf_pkg::tree_req_t                  tree_req,
    output rapsf_pkg::result_t                    result,
    output rapsf_pkg::alu_req_t                   alu_req,
    input  logic [rapsf_pkg::SUM_WIDTH-1:0]       alu_result
);
    import rapsf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_MUL2,
        S_A_RD,
        S_A_WR,
        S_Q_RD,
        S_Q_ACC,
        S_Q_MUL,
        S_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic                    cmd_reg, cmd_next;
    logic signed [EXT_W-1:0] pl_reg, pl_next;
    logic signed [EXT_W-1:0] ph_reg, ph_next;
    logic [AMT_W-1:0]        amt_reg, amt_next;
    logic [POS_W-1:0]        n_reg, n_next;
    logic [POS_W-1:0]        q_reg, q_next;
    logic [WALK_W-1:0]       pos_reg, pos_next;
    logic                    phase_reg, phase_next;
    logic [SUM_WIDTH-1:0]    ds_reg, ds_next;
    logic [SUM_WIDTH-1:0]    do_reg, do_next;
    logic [SUM_WIDTH-1:0]    doff2_reg, doff2_next;
    logic [SUM_WIDTH-1:0]    acc_s_reg, acc_s_next;
    logic [SUM_WIDTH-1:0]    acc_o_reg, acc_o_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [SUM_WIDTH-1:0]    sum_reg, sum_next;
    logic                    status_reg, status_next;

    logic [WALK_W-1:0]       lowbit;
    logic [WALK_W-1:0]       pos_m1;
    logic                    pos_in_range;
    logic [SUM_WIDTH-1:0]    amt_ext;
    logic signed [EXT_W-1:0] n_ext;
    logic                    pl_pos;
    logic                    ph_pos;

    assign lowbit       = pos_reg & (~pos_reg + WALK_W'(1));
    assign pos_m1       = pos_reg - WALK_W'(1);
    assign pos_in_range = (pos_reg != '0) && (pos_reg <= {{(WALK_W-POS_W){1'b0}}, n_reg});
    assign amt_ext      = {{(SUM_WIDTH-AMT_W){amt_reg[AMT_W-1]}}, amt_reg};
    assign n_ext        = $signed({{(EXT_W-POS_W){1'b0}}, n_reg});
    assign pl_pos       = !pl_reg[EXT_W-1] && (pl_reg != '0);
    assign ph_pos       = !ph_reg[EXT_W-1] && (ph_reg != '0);

    assign item_stall   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pl_next     = pl_reg;
        ph_next     = ph_reg;
        amt_next    = amt_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        ds_next     = ds_reg;
        do_next     = do_reg;
        doff2_next  = doff2_reg;
        acc_s_next  = acc_s_reg;
        acc_o_next  = acc_o_reg;
        clr_next    = clr_reg;
        sum_next    = sum_reg;
        status_next = status_reg;

        tree_req.we           = 1'b0;
        tree_req.addr         = pos_m1[ADDR_W-1:0];
        tree_req.slope_wdata  = slope_rdata + ds_reg;
        tree_req.offset_wdata = offset_rdata + do_reg;

        alu_req.mul_a = amt_ext;
        alu_req.mul_b = ph_reg;
        alu_req.add_c = '0;

        result.load   = 1'b0;
        result.sum    = sum_reg;
        result.status = status_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                tree_req.we           = 1'b1;
                tree_req.addr         = clr_reg;
                tree_req.slope_wdata  = '0;
                tree_req.offset_wdata = '0;
                clr_next              = clr_reg + ADDR_W'(1);
                if (clr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next   = command;
                    pl_next    = $signed({{2{low_index[IDX_W-1]}}, low_index})
                               - $signed({{2{base_index[IDX_W-1]}}, base_index})
                               + EXT_W'(1);
                    ph_next    = $signed({{2{high_index[IDX_W-1]}}, high_index})
                               - $signed({{2{base_index[IDX_W-1]}}, base_index})
                               + EXT_W'(1);
                    amt_next   = amount;
                    n_next     = n_eff;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    // clamp the prefix end into [0, n]
                    if (!ph_pos)
                    begin
                        q_next = '0;
                    end
                    else if (ph_reg > n_ext)
                    begin
                        q_next = n_reg;
                    end
                    else
                    begin
                        q_next = ph_reg[POS_W-1:0];
                    end
                    pos_next   = {{(WALK_W-POS_W){1'b0}}, q_next};
                    acc_s_next = '0;
                    acc_o_next = '0;
                    state_next = S_Q_RD;
                end
                else if (!(pl_pos && ph_pos))
                begin
                    sum_next    = '0;
                    status_next = STATUS_REJECT;
                    state_next  = S_FIN;
                end
                else
                begin
                    // offset delta of the low end: amount * (1 - pl)
                    alu_req.mul_b = EXT_W'(1) - pl_reg;
                    do_next       = alu_result;
                    ds_next       = amt_ext;
                    pos_next      = pl_reg[WALK_W-1:0];
                    phase_next    = 1'b0;
                    state_next    = S_MUL2;
                end
            end
            S_MUL2:
            begin
                doff2_next = alu_result;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                if (pos_in_range)
                begin
                    state_next = S_A_WR;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    pos_next   = ph_reg[WALK_W-1:0];
                    ds_next    = '0 - ds_reg;
                    do_next    = doff2_reg;
                end
                else
                begin
                    sum_next    = '0;
                    status_next = STATUS_DONE;
                    state_next  = S_FIN;
                end
            end
            S_A_WR:
            begin
                tree_req.we = 1'b1;
                pos_next    = pos_reg + lowbit;
                state_next  = S_A_RD;
            end
            S_Q_RD:
            begin
                if (pos_reg != '0)
                begin
                    state_next = S_Q_ACC;
                end
                else
                begin
                    state_next = S_Q_MUL;
                end
            end
            S_Q_ACC:
            begin
                acc_s_next = acc_s_reg + slope_rdata;
                acc_o_next = acc_o_reg + offset_rdata;
                pos_next   = pos_reg - lowbit;
                state_next = S_Q_RD;
            end
            S_Q_MUL:
            begin
                alu_req.mul_a = acc_s_reg;
                alu_req.mul_b = {{(EXT_W-POS_W){1'b0}}, q_reg};
                alu_req.add_c = acc_o_reg;
                sum_next      = alu_result;
                status_next   = STATUS_DONE;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                result.load = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cmd_reg    <= CMD_ADD;
            pl_reg     <= '0;
            ph_reg     <= '0;
            amt_reg    <= '0;
            n_reg      <= '0;
            q_reg      <= '0;
            pos_reg    <= '0;
            phase_reg  <= 1'b0;
            ds_reg     <= '0;
            do_reg     <= '0;
            doff2_reg  <= '0;
            acc_s_reg  <= '0;
            acc_o_reg  <= '0;
            clr_reg    <= '0;
            sum_reg    <= '0;
            status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            amt_reg    <= amt_next;
            n_reg      <= n_next;
            q_reg      <= q_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            ds_reg     <= ds_next;
            do_reg     <= do_next;
            doff2_reg  <= doff2_next;
            acc_s_reg  <= acc_s_next;
            acc_o_reg  <= acc_o_next;
            clr_reg    <= clr_next;
            sum_reg    <= sum_next;
            status_reg <= status_next;
        end
    end

endmodule

/* rtl/core/range_add_prefix_sum_fenwick_top.sv */
`timescale 1ns / 1ps
// Top level: range-add / prefix-sum Fenwick tree with APB configuration.
//
// Range add over [low_index, high_index] and prefix-sum query on a binary
// indexed tree pair (slope and offset trees, 1024 entries of 48 bits each,
// held in two RAMs with registered reads). After reset the block sweeps both
// RAMs to zero, one entry per cycle, and holds item_stall high until the sweep
// ends; configuration writes are taken during the sweep. Each item then
// runs alone under a small sequencer that shares one 48x18 multiply-add unit:
// an add forms the offset deltas of both ends, then walks up from each end;
// a query clamps its position, sums the entries on its walk down, then
// multiplies. The walk is limited by the single RAM read per position and
// the read-modify-write of each visited entry. The result sits in an output
// register, so the next item is accepted while a result waits for the
// downstream side. An add whose low or high end falls below position one
// returns status 1 and leaves the trees unchanged.
module range_add_prefix_sum_fenwick_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rapsf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [rapsf_pkg::DATA_W-1:0]          pwdata,
    output logic [rapsf_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  command,
    input  logic signed [rapsf_pkg::IDX_W-1:0]    low_index,
    input  logic signed [rapsf_pkg::IDX_W-1:0]    high_index,
    input  logic signed [rapsf_pkg::AMT_W-1:0]    amount,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [rapsf_pkg::SUM_WIDTH-1:0] prefix_sum,
    output logic                                  status
);
    import rapsf_pkg::*;

    logic signed [IDX_W-1:0] base_index_reg;
    logic [POS_W-1:0]        positions_reg;
    logic [POS_W-1:0]        n_eff;
    logic                    cfg_write;

    logic                    result_valid_reg;
    logic [SUM_WIDTH-1:0]    prefix_sum_reg;
    logic                    status_reg;
    logic                    out_free;

    tree_req_t               tree_req;
    result_t                 seq_result;
    alu_req_t                alu_req;
    logic [SUM_WIDTH-1:0]    alu_result;
    logic [SUM_WIDTH-1:0]    slope_rdata;
    logic [SUM_WIDTH-1:0]    offset_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_index_reg <= '0;
            positions_reg  <= POS_W'(TREE_SIZE);
        end
        else if (cfg_write)
        begin
            if (paddr[CFG_ADDR_W-1] == REG_POSITIONS)
            begin
                positions_reg <= pwdata[POS_W-1:0];
            end
            else
            begin
                base_index_reg <= pwdata[IDX_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[CFG_ADDR_W-1] == REG_POSITIONS)
        begin
            prdata = {{(DATA_W-POS_W){1'b0}}, positions_reg};
        end
        else
        begin
            prdata = {{(DATA_W-IDX_W){1'b0}}, base_index_reg};
        end
    end

    assign n_eff = (positions_reg > POS_W'(TREE_SIZE)) ? POS_W'(TREE_SIZE) : positions_reg;

    rapsf_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .low_index    (low_index),
        .high_index   (high_index),
        .amount       (amount),
        .base_index   (base_index_reg),
        .n_eff        (n_eff),
        .out_free     (out_free),
        .slope_rdata  (slope_rdata),
        .offset_rdata (offset_rdata),
        .tree_req     (tree_req),
        .result       (seq_result),
        .alu_req      (alu_req),
        .alu_result   (alu_result)
    );

    rapsf_alu u_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    rapsf_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (TREE_SIZE)
    ) u_slope_ram (
        .clk   (clk),
        .we    (tree_req.we),
        .waddr (tree_req.addr),
        .wdata (tree_req.slope_wdata),
        .raddr (tree_req.addr),
        .rdata (slope_rdata)
    );

    rapsf_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (TREE_SIZE)
    ) u_offset_ram (
        .clk   (clk),
        .we    (tree_req.we),
        .waddr (tree_req.addr),
        .wdata (tree_req.offset_wdata),
        .raddr (tree_req.addr),
        .rdata (offset_rdata)
    );

    // output register decouples the sequencer from the result stall
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            prefix_sum_reg   <= '0;
            status_reg       <= STATUS_DONE;
        end
        else if (seq_result.load)
        begin
            result_valid_reg <= 1'b1;
            prefix_sum_reg   <= seq_result.sum;
            status_reg       <= seq_result.status;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign prefix_sum   = prefix_sum_reg;
    assign status       = status_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_result.load |-> (!result_valid_reg || !result_stall))
        else $error("result loaded over a pending transfer");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second item accepted while the first is in flight");

    a_reject_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg == STATUS_REJECT) |-> (prefix_sum_reg == '0))
        else $error("rejected add carries a nonzero sum");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !item_stall |-> !tree_req.we)
        else $error("tree written while idle");

endmodule

/* verif/range_add_prefix_sum_fenwick_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the range-add prefix-sum Fenwick tree top level.
module range_add_prefix_sum_fenwick_top_test;
    import rapsf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic                    cmd;
        logic signed [IDX_W-1:0] lo;
        logic signed [IDX_W-1:0] hi;
        logic signed [AMT_W-1:0] amt;
    } tree_cmd_t;

    typedef struct {
        logic [SUM_WIDTH-1:0] sum;
        logic                 status;
    } answer_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    logic                    command = CMD_ADD;
    logic signed [IDX_W-1:0] low_index = '0;
    logic signed [IDX_W-1:0] high_index = '0;
    logic signed [AMT_W-1:0] amount = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic signed [SUM_WIDTH-1:0] prefix_sum;
    logic                    status;

    range_add_prefix_sum_fenwick_top DUT (.*);

    // tree copy and register shadow
    logic [SUM_WIDTH-1:0] slope_sums [0:TREE_SIZE];
    logic [SUM_WIDTH-1:0] offset_sums [0:TREE_SIZE];
    int                   cfg_base = 0;
    logic [10:0]          cfg_positions = 11'd1024;

    tree_cmd_t command_queue[$];
    answer_t   answer_queue[$];
    tree_cmd_t next_cmd;
    answer_t   got_answer;
    answer_t   want_answer;

    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    int gap_left = 0;
    int error_count = 0;
    int cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        for (int i = 0; i <= TREE_SIZE; i++) begin
            slope_sums[i] = '0;
            offset_sums[i] = '0;
        end
    end

    function automatic int active_positions();
        return (cfg_positions > TREE_SIZE) ? TREE_SIZE : int'(cfg_positions);
    endfunction

    function automatic void walk_up(int pos, logic [SUM_WIDTH-1:0] d_slope,
                                    logic [SUM_WIDTH-1:0] d_offset);
        int n;
        n = active_positions();
        while (pos >= 1 && pos <= n) begin
            slope_sums[pos] = slope_sums[pos] + d_slope;
            offset_sums[pos] = offset_sums[pos] + d_offset;
            pos += pos & -pos;
        end
    endfunction

    function automatic logic [SUM_WIDTH-1:0] prefix_total(int q);
        logic [SUM_WIDTH-1:0] s;
        logic [SUM_WIDTH-1:0] o;
        logic [SUM_WIDTH-1:0] r;
        int p;
        s = '0;
        o = '0;
        p = q;
        while (p > 0) begin
            s = s + slope_sums[p];
            o = o + offset_sums[p];
            p -= p & -p;
        end
        r = s * SUM_WIDTH'(q) + o;
        return r;
    endfunction

    // applies one transfer to the tree copy and returns the answer it produces
    function automatic answer_t compute_answer(logic cmd, logic signed [IDX_W-1:0] lo_x,
                                               logic signed [IDX_W-1:0] hi_x,
                                               logic signed [AMT_W-1:0] amt_x);
        answer_t r;
        int      lo;
        int      hi;
        int      n;
        longint  amt;
        lo = int'(lo_x) - cfg_base + 1;
        hi = int'(hi_x) - cfg_base + 1;
        amt = longint'(amt_x);
        n = active_positions();
        r.sum = '0;
        r.status = STATUS_DONE;
        if (cmd == CMD_QUERY) begin
            if (hi >= 1)
                r.sum = prefix_total((hi > n) ? n : hi);
        end else if (lo < 1 || hi < 1) begin
            r.status = STATUS_REJECT;
        end else begin
            walk_up(lo, SUM_WIDTH'(amt), SUM_WIDTH'(-amt * longint'(lo - 1)));
            walk_up(hi, SUM_WIDTH'(-amt), SUM_WIDTH'(amt * longint'(hi)));
        end
        return r;
    endfunction

    // sender: holds the payload while stalled, random gaps between transfers
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && !item_stall)
                answer_queue.push_back(compute_answer(command, low_index, high_index, amount));
            if (!item_valid || !item_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    item_valid <= 1'b0;
                end else if (command_queue.size() != 0 && idle_on
                             && $urandom_range(0, 3) == 0) begin
                    gap_left <= $urandom_range(0, 9);
                    item_valid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    next_cmd = command_queue.pop_front();
                    command <= next_cmd.cmd;
                    low_index <= next_cmd.lo;
                    high_index <= next_cmd.hi;
                    amount <= next_cmd.amt;
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks results, drives stall bursts and the one long hold-off
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                got_answer.sum = prefix_sum;
                got_answer.status = status;
                if (answer_queue.size() == 0) begin
                    $error("unexpected result: prefix_sum %0d status %0b", prefix_sum, status);
                    error_count++;
                end else begin
                    want_answer = answer_queue.pop_front();
                    if (got_answer.sum !== want_answer.sum) begin
                        $error("prefix_sum: expected %0d, actual %0d",
                               $signed(want_answer.sum), $signed(got_answer.sum));
                        error_count++;
                    end
                    if (got_answer.status !== want_answer.status) begin
                        $error("status: expected %0b, actual %0b",
                               want_answer.status, got_answer.status);
                        error_count++;
                    end
                end
            end
            if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_CYCLES;
                result_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                result_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                result_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left <= $urandom_range(0, 9);
                result_stall <= 1'b1;
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic reg_sel, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_BASE)
            cfg_base = int'($signed(value[IDX_W-1:0]));
        else
            cfg_positions = value[10:0];
    endtask

    task automatic wait_drained();
        while (command_queue.size() != 0 || item_valid || answer_queue.size() != 0)
            @(negedge clk);
    endtask

    function automatic void queue_cmd(logic cmd, int lo, int hi, int amt);
        tree_cmd_t c;
        c.cmd = cmd;
        c.lo = IDX_W'(lo);
        c.hi = IDX_W'(hi);
        c.amt = AMT_W'(amt);
        command_queue.push_back(c);
    endfunction

    // external index for a tree position; unrepresentable ones become noise
    function automatic logic signed [IDX_W-1:0] index_of(int p);
        int x;
        x = cfg_base + p - 1;
        if (x < -32768 || x > 32767)
            return IDX_W'($urandom_range(0, 65535));
        return IDX_W'(x);
    endfunction

    function automatic void queue_random(int count);
        tree_cmd_t c;
        int        n;
        int        p_lo;
        int        p_hi;
        int        t;
        n = (active_positions() < 1) ? 1 : active_positions();
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 80) begin
                p_lo = $urandom_range(1, n);
                p_hi = $urandom_range(p_lo, n);
                case ($urandom_range(0, 19))
                    0, 1: p_hi = n + $urandom_range(1, 40);
                    2:    p_lo = 1 - $urandom_range(1, 4);
                    3:    p_hi = 1 - $urandom_range(1, 4);
                    4:    begin t = p_lo; p_lo = p_hi; p_hi = t; end
                    default: ;
                endcase
                c.cmd = 1'($urandom_range(0, 1));
                c.lo = index_of(p_lo);
                c.hi = index_of(p_hi);
                case ($urandom_range(0, 9))
                    0:       c.amt = {1'b0, {(AMT_W-1){1'b1}}};
                    1:       c.amt = {1'b1, {(AMT_W-1){1'b0}}};
                    default: c.amt = AMT_W'($urandom_range(0, 65535));
                endcase
            end else begin
                c.cmd = 1'($urandom_range(0, 1));
                c.lo = IDX_W'($urandom_range(0, 65535));
                c.hi = IDX_W'($urandom_range(0, 65535));
                c.amt = AMT_W'($urandom_range(0, 65535));
            end
            command_queue.push_back(c);
        end
    endfunction

    task automatic run_phase(int base, int positions, int count, bit idle, bit hold);
        write_reg(REG_BASE, DATA_W'(base));
        write_reg(REG_POSITIONS, DATA_W'(positions));
        @(negedge clk);
        idle_on = idle;
        if (hold)
            hold_request = 1'b1;
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // register writes are taken during the clearing sweep
        write_reg(REG_BASE, DATA_W'(0));
        write_reg(REG_POSITIONS, DATA_W'(1024));
        @(negedge clk);
        queue_cmd(CMD_ADD, 0, 1023, 32767);
        queue_cmd(CMD_ADD, 0, 0, -32768);
        queue_cmd(CMD_QUERY, 0, 1023, 0);
        queue_cmd(CMD_QUERY, 32767, 0, -1);
        queue_cmd(CMD_QUERY, 0, -1, 0);           // below first position
        queue_cmd(CMD_QUERY, -32768, 32767, 0);   // clamped to the last position
        queue_cmd(CMD_ADD, -1, 10, 5);            // low end below first position
        queue_cmd(CMD_ADD, 5, -32768, 9);         // high end below first position
        queue_cmd(CMD_ADD, -32768, 32767, -1);
        queue_cmd(CMD_ADD, 1000, 32767, 12345);   // clipped at the last position
        queue_cmd(CMD_ADD, 2000, 3000, 99);
        queue_cmd(CMD_ADD, 500, 100, 77);         // reversed range
        queue_cmd(CMD_ADD, 300, 700, 0);
        queue_cmd(CMD_QUERY, 0, 511, 0);
        queue_cmd(CMD_QUERY, 0, 100, 0);
        queue_cmd(CMD_QUERY, 0, 1022, 0);
        queue_cmd(CMD_QUERY, 0, -32768, 32767);
        queue_cmd(CMD_ADD, 1023, 1023, -32768);
        queue_cmd(CMD_QUERY, -1, 1023, -1);
        queue_cmd(CMD_QUERY, 0, 32767, 0);
        wait_drained();

        run_phase(-32768, 1024, 250, 1'b1, 1'b1);
        run_phase(-100, 1024, 200, 1'b1, 1'b0);
        run_phase(32767, 1, 100, 1'b1, 1'b0);
        run_phase(int'($signed(16'($urandom_range(0, 65535)))), 1, 100, 1'b1, 1'b0);
        run_phase(int'($signed(16'($urandom_range(0, 65535)))), 0, 100, 1'b1, 1'b0);
        run_phase(-200, 2047, 150, 1'b1, 1'b0);     // above tree size, treated as full
        run_phase(7, 2, 100, 1'b1, 1'b0);
        run_phase(int'($signed(16'($urandom_range(0, 65535)))),
                  $urandom_range(1, 1024), 200, 1'b1, 1'b0);
        run_phase(-50, 1024, 300, 1'b0, 1'b0);      // no idling on either side

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && answer_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
